/* sv/tcce_pkg.sv */
// Shared types and constants for the text console cursor engine.
// Used by tcce_ctrl, tcce_dp and text_console_cursor_engine_top. No dependencies.
package tcce_pkg;

  localparam int DefTextRows = 30;
  localparam int DefTextCols = 40;

  localparam int KindW  = 3;
  localparam int ByteW  = 8;
  localparam int ColW   = 6;
  localparam int RowW   = 5;
  localparam int ReqW   = 2;
  localparam int ModeW  = 2;
  localparam int DataW  = 32;
  localparam int PaddrW = 3;

  localparam logic [ModeW-1:0] MODE_SERIAL  = 2'd0;
  localparam logic [ModeW-1:0] MODE_DISPLAY = 2'd1;
  localparam logic [ModeW-1:0] MODE_MIRROR  = 2'd2;

  localparam logic [PaddrW-3:0] REG_OUTPUT_MODE = 1'b0;

  localparam logic [ByteW-1:0] CH_BS         = 8'd8;
  localparam logic [ByteW-1:0] CH_LF         = 8'd10;
  localparam logic [ByteW-1:0] CH_CR         = 8'd13;
  localparam logic [ByteW-1:0] CH_SPACE      = 8'd32;
  localparam logic [ByteW-1:0] CH_QMARK      = 8'd63;
  localparam logic [ByteW-1:0] CH_FIRST_PRNT = 8'd32;
  localparam logic [ByteW-1:0] CH_LAST_PRNT  = 8'd126;

  typedef enum logic [ReqW-1:0] {
    REQ_PUT   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2
  } req_type_e;

  typedef enum logic [KindW-1:0] {
    EVT_SERIAL = 3'd0,
    EVT_DRAW   = 3'd1,
    EVT_SCROLL = 3'd2,
    EVT_CLEAR  = 3'd3,
    EVT_READ   = 3'd4
  } evt_kind_e;

  typedef struct packed {
    logic      accept;
    logic      fill_step;
    logic      fill_zero;
    logic      draw_wr;
    logic      mem_rd;
    logic      load_out;
    evt_kind_e out_kind;
    logic      out_last;
  } tcce_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic do_serial;
    logic do_draw;
    logic do_scroll;
    logic do_clear;
    logic clear_evt;
    logic do_read;
    logic row_end;
    logic last_row;
    logic out_free;
  } tcce_sts_t;

endpackage

/* sv/tcce_ctrl.sv */
// Sequencing state machine for the text console cursor engine.
// Depends on tcce_pkg; drives tcce_dp through tcce_cmd_t and reads tcce_sts_t.
module tcce_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tcce_pkg::tcce_sts_t sts_i,
  output tcce_pkg::tcce_cmd_t cmd_o,
  output logic               in_ready_o
);

  typedef enum logic [9:0] {
    ST_INIT       = 10'b00_0000_0001,
    ST_IDLE       = 10'b00_0000_0010,
    ST_SERIAL     = 10'b00_0000_0100,
    ST_DRAW       = 10'b00_0000_1000,
    ST_FILL       = 10'b00_0001_0000,
    ST_SCROLL_EV  = 10'b00_0010_0000,
    ST_CLEAR_FILL = 10'b00_0100_0000,
    ST_CLEAR_EV   = 10'b00_1000_0000,
    ST_READ_MEM   = 10'b01_0000_0000,
    ST_READ_EV    = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   draw_q, draw_d;
  logic   scroll_q, scroll_d;
  logic   clr_evt_q, clr_evt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      draw_q    <= 1'b0;
      scroll_q  <= 1'b0;
      clr_evt_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      draw_q    <= draw_d;
      scroll_q  <= scroll_d;
      clr_evt_q <= clr_evt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    draw_d     = draw_q;
    scroll_d   = scroll_q;
    clr_evt_d  = clr_evt_q;
    cmd_o      = '0;
    cmd_o.out_kind = tcce_pkg::EVT_SERIAL;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.fill_step = 1'b1;
        cmd_o.fill_zero = 1'b1;
        if (sts_i.row_end && sts_i.last_row) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (sts_i.in_valid) begin
          cmd_o.accept = 1'b1;
          draw_d    = sts_i.do_draw;
          scroll_d  = sts_i.do_scroll;
          clr_evt_d = sts_i.clear_evt;
          if (sts_i.do_serial) begin
            state_d = ST_SERIAL;
          end else if (sts_i.do_draw) begin
            state_d = ST_DRAW;
          end else if (sts_i.do_scroll) begin
            state_d = ST_FILL;
          end else if (sts_i.do_clear) begin
            state_d = ST_CLEAR_FILL;
          end else if (sts_i.do_read) begin
            state_d = ST_READ_MEM;
          end
        end
      end
      ST_SERIAL: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_kind = tcce_pkg::EVT_SERIAL;
          cmd_o.out_last = !draw_q && !scroll_q;
          if (draw_q) begin
            state_d = ST_DRAW;
          end else if (scroll_q) begin
            state_d = ST_FILL;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_DRAW: begin
        if (sts_i.out_free) begin
          cmd_o.draw_wr  = 1'b1;
          cmd_o.load_out = 1'b1;
          cmd_o.out_kind = tcce_pkg::EVT_DRAW;
          cmd_o.out_last = !scroll_q;
          state_d = scroll_q ? ST_FILL : ST_IDLE;
        end
      end
      ST_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.row_end) begin
          state_d = ST_SCROLL_EV;
        end
      end
      ST_SCROLL_EV: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_kind = tcce_pkg::EVT_SCROLL;
          cmd_o.out_last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_CLEAR_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.row_end && sts_i.last_row) begin
          state_d = clr_evt_q ? ST_CLEAR_EV : ST_IDLE;
        end
      end
      ST_CLEAR_EV: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_kind = tcce_pkg::EVT_CLEAR;
          cmd_o.out_last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_READ_MEM: begin
        cmd_o.mem_rd = 1'b1;
        state_d = ST_READ_EV;
      end
      ST_READ_EV: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_kind = tcce_pkg::EVT_READ;
          cmd_o.out_last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/tcce_dp.sv */
// Datapath of the text console cursor engine: cursor, row ring, character
// memory, mode register and output word register. Depends on tcce_pkg.
module tcce_dp #(
  parameter int TEXT_ROWS = tcce_pkg::DefTextRows,
  parameter int TEXT_COLS = tcce_pkg::DefTextCols
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tcce_pkg::tcce_cmd_t         cmd_i,
  output tcce_pkg::tcce_sts_t         sts_o,
  input  logic                        in_valid_i,
  input  logic [tcce_pkg::ReqW-1:0]   req_type_i,
  input  logic [tcce_pkg::ByteW-1:0]  char_code_i,
  input  logic [tcce_pkg::ColW-1:0]   read_col_i,
  input  logic [tcce_pkg::RowW-1:0]   read_row_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tcce_pkg::KindW-1:0]  event_kind_o,
  output logic [tcce_pkg::ByteW-1:0]  byte_value_o,
  output logic [tcce_pkg::ColW-1:0]   cell_col_o,
  output logic [tcce_pkg::RowW-1:0]   cell_row_o,
  output logic                        last_of_run_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcce_pkg::PaddrW-1:0] paddr,
  input  logic [tcce_pkg::DataW-1:0]  pwdata,
  output logic [tcce_pkg::DataW-1:0]  prdata,
  output logic                        pready
);

  localparam int COL_W  = (TEXT_COLS > 1) ? $clog2(TEXT_COLS) : 1;
  localparam int ROW_W  = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(TEXT_COLS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(TEXT_ROWS - 1);
  localparam logic [ROW_W:0]   ROWS_EXT = (ROW_W+1)'(TEXT_ROWS);

  // ring-mapped row: logical row plus top of ring, modulo row count
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                input logic [ROW_W-1:0] t);
    logic [ROW_W:0] s;
    s = {1'b0, r} + {1'b0, t};
    if (s >= ROWS_EXT) begin
      s = s - ROWS_EXT;
    end
    return s[ROW_W-1:0];
  endfunction

  logic [tcce_pkg::ByteW-1:0] mem [DEPTH];

  logic [tcce_pkg::ModeW-1:0] mode_q;
  logic [COL_W-1:0]           cur_col_q, cur_col_d;
  logic [ROW_W-1:0]           cur_row_q, cur_row_d;
  logic [ROW_W-1:0]           top_q, top_d;
  logic [COL_W-1:0]           sw_col_q;
  logic [ROW_W-1:0]           sw_row_q;
  logic                       out_valid_q;

  logic [tcce_pkg::ByteW-1:0] ser_char_q;
  logic [tcce_pkg::ByteW-1:0] draw_char_q;
  logic [COL_W-1:0]           draw_col_q;
  logic [ROW_W-1:0]           draw_row_q;
  logic [ADDR_W-1:0]          draw_addr_q;
  logic [tcce_pkg::ColW-1:0]  rd_col_q;
  logic [tcce_pkg::RowW-1:0]  rd_row_q;
  logic [ADDR_W-1:0]          rd_addr_q;
  logic                       rd_oob_q;
  logic [tcce_pkg::ByteW-1:0] rd_data_q;

  logic [tcce_pkg::KindW-1:0] out_kind_q;
  logic [tcce_pkg::ByteW-1:0] out_byte_q;
  logic [tcce_pkg::ColW-1:0]  out_col_q;
  logic [tcce_pkg::RowW-1:0]  out_row_q;
  logic                       out_last_q;

  logic is_put, disp, serial, is_cr, is_lf, is_bs;
  logic draw, printable, newline, scroll, is_clear, is_read;
  logic at_last_col, at_last_row, oob;
  logic [COL_W-1:0]           draw_col;
  logic [tcce_pkg::ByteW-1:0] draw_char;
  logic [ROW_W-1:0]           top_inc;
  logic                       cfg_wr, cfg_hit;
  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic [tcce_pkg::ByteW-1:0] mem_wdata;

  // request decode
  assign is_put   = req_type_i == tcce_pkg::REQ_PUT;
  assign is_clear = req_type_i == tcce_pkg::REQ_CLEAR;
  assign is_read  = req_type_i == tcce_pkg::REQ_READ;
  assign disp     = is_put && (mode_q != tcce_pkg::MODE_SERIAL);
  assign serial   = is_put && (mode_q != tcce_pkg::MODE_DISPLAY);
  assign is_cr    = char_code_i == tcce_pkg::CH_CR;
  assign is_lf    = char_code_i == tcce_pkg::CH_LF;
  assign is_bs    = char_code_i == tcce_pkg::CH_BS;
  assign draw     = disp && !is_cr && !is_lf;
  assign printable   = draw && !is_bs;
  assign at_last_col = cur_col_q == LAST_COL;
  assign at_last_row = cur_row_q == LAST_ROW;
  assign newline  = (disp && is_lf) || (printable && at_last_col);
  assign scroll   = newline && at_last_row;
  assign top_inc  = (top_q == LAST_ROW) ? '0 : top_q + ROW_W'(1);
  assign draw_col = (is_bs && (cur_col_q != '0)) ? cur_col_q - COL_W'(1) : cur_col_q;
  assign oob = !((32'(read_col_i) < 32'(TEXT_COLS)) && (32'(read_row_i) < 32'(TEXT_ROWS)));

  always_comb begin
    if (is_bs) begin
      draw_char = tcce_pkg::CH_SPACE;
    end else if ((char_code_i < tcce_pkg::CH_FIRST_PRNT) ||
                 (char_code_i > tcce_pkg::CH_LAST_PRNT)) begin
      draw_char = tcce_pkg::CH_QMARK;
    end else begin
      draw_char = char_code_i;
    end
  end

  always_comb begin
    sts_o.in_valid  = in_valid_i;
    sts_o.do_serial = serial;
    sts_o.do_draw   = draw;
    sts_o.do_scroll = scroll;
    sts_o.do_clear  = is_clear;
    sts_o.clear_evt = is_clear && (mode_q != tcce_pkg::MODE_SERIAL);
    sts_o.do_read   = is_read;
    sts_o.row_end   = sw_col_q == LAST_COL;
    sts_o.last_row  = sw_row_q == LAST_ROW;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // cursor and ring update on accept
  always_comb begin
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    top_d     = top_q;
    if (is_clear) begin
      cur_col_d = '0;
      cur_row_d = '0;
      top_d     = '0;
    end else if (disp) begin
      if (is_cr) begin
        cur_col_d = '0;
      end else if (newline) begin
        cur_col_d = '0;
        if (at_last_row) begin
          top_d = top_inc;
        end else begin
          cur_row_d = cur_row_q + ROW_W'(1);
        end
      end else if (is_bs) begin
        cur_col_d = draw_col;
      end else begin
        cur_col_d = cur_col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q <= '0;
      cur_row_q <= '0;
      top_q     <= '0;
      sw_col_q  <= '0;
      sw_row_q  <= '0;
    end else if (cmd_i.accept) begin
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      top_q     <= top_d;
      sw_col_q  <= '0;
      sw_row_q  <= is_clear ? '0 : top_q;
    end else if (cmd_i.fill_step) begin
      if (sw_col_q == LAST_COL) begin
        sw_col_q <= '0;
        sw_row_q <= sw_row_q + ROW_W'(1);
      end else begin
        sw_col_q <= sw_col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ser_char_q  <= char_code_i;
      draw_char_q <= draw_char;
      draw_col_q  <= draw_col;
      draw_row_q  <= cur_row_q;
      draw_addr_q <= {phys_row(cur_row_q, top_q), draw_col};
      rd_col_q    <= read_col_i;
      rd_row_q    <= read_row_i;
      rd_addr_q   <= {phys_row(ROW_W'(read_row_i), top_q), COL_W'(read_col_i)};
      rd_oob_q    <= oob;
    end
  end

  // character memory, one access per cycle
  assign mem_we    = cmd_i.fill_step || cmd_i.draw_wr;
  assign mem_waddr = cmd_i.fill_step ? {sw_row_q, sw_col_q} : draw_addr_q;
  assign mem_wdata = cmd_i.fill_step ? (cmd_i.fill_zero ? '0 : tcce_pkg::CH_SPACE)
                                     : draw_char_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.mem_rd) begin
      rd_data_q <= mem[rd_addr_q];
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_kind_q <= cmd_i.out_kind;
      out_last_q <= cmd_i.out_last;
      case (cmd_i.out_kind)
        tcce_pkg::EVT_SERIAL: begin
          out_byte_q <= ser_char_q;
          out_col_q  <= '0;
          out_row_q  <= '0;
        end
        tcce_pkg::EVT_DRAW: begin
          out_byte_q <= draw_char_q;
          out_col_q  <= tcce_pkg::ColW'(draw_col_q);
          out_row_q  <= tcce_pkg::RowW'(draw_row_q);
        end
        tcce_pkg::EVT_READ: begin
          out_byte_q <= rd_oob_q ? '0 : rd_data_q;
          out_col_q  <= rd_col_q;
          out_row_q  <= rd_row_q;
        end
        default: begin
          out_byte_q <= '0;
          out_col_q  <= '0;
          out_row_q  <= '0;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = out_kind_q;
  assign byte_value_o  = out_byte_q;
  assign cell_col_o    = out_col_q;
  assign cell_row_o    = out_row_q;
  assign last_of_run_o = out_last_q;

  // mode register; writes above mirror saturate
  assign cfg_hit = paddr[tcce_pkg::PaddrW-1:2] == tcce_pkg::REG_OUTPUT_MODE;
  assign cfg_wr  = psel && penable && pwrite && cfg_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tcce_pkg::MODE_MIRROR;
    end else if (cfg_wr) begin
      mode_q <= (pwdata > tcce_pkg::DataW'(tcce_pkg::MODE_MIRROR)) ? tcce_pkg::MODE_MIRROR
                                                                  : pwdata[tcce_pkg::ModeW-1:0];
    end
  end

  assign prdata = cfg_hit ? tcce_pkg::DataW'(mode_q) : '0;
  assign pready = 1'b1;

endmodule

/* sv/text_console_cursor_engine_top.sv */
// Top level of the text console cursor engine.
// Depends on tcce_pkg, tcce_ctrl and tcce_dp.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-----------------------------------------
//   request  | in_valid_i / in_ready_o | req_type_i char_code_i read_col_i read_row_i
//   result   | out_valid_o/out_ready_i | event_kind_o byte_value_o cell_col_o
//            |                         | cell_row_o last_of_run_o
//   config   | psel penable pwrite     | paddr pwdata prdata (pready tied high)
//
// One request at a time, set by the single-port character memory. A put that
// scrolls also fills the new bottom row with spaces; a clear fills every cell with
// spaces and then, outside serial mode, emits its event.
// After reset a zero-fill pass over every cell runs before the
// first request is taken. A stalled result word holds the sequencer in place.
module text_console_cursor_engine_top #(
  parameter int TEXT_ROWS = tcce_pkg::DefTextRows,
  parameter int TEXT_COLS = tcce_pkg::DefTextCols
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tcce_pkg::ReqW-1:0]   req_type_i,
  input  logic [tcce_pkg::ByteW-1:0]  char_code_i,
  input  logic [tcce_pkg::ColW-1:0]   read_col_i,
  input  logic [tcce_pkg::RowW-1:0]   read_row_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tcce_pkg::KindW-1:0]  event_kind_o,
  output logic [tcce_pkg::ByteW-1:0]  byte_value_o,
  output logic [tcce_pkg::ColW-1:0]   cell_col_o,
  output logic [tcce_pkg::RowW-1:0]   cell_row_o,
  output logic                        last_of_run_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcce_pkg::PaddrW-1:0] paddr,
  input  logic [tcce_pkg::DataW-1:0]  pwdata,
  output logic [tcce_pkg::DataW-1:0]  prdata,
  output logic                        pready
);

  tcce_pkg::tcce_cmd_t cmd;
  tcce_pkg::tcce_sts_t sts;

  tcce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  tcce_dp #(
    .TEXT_ROWS (TEXT_ROWS),
    .TEXT_COLS (TEXT_COLS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_valid_i    (in_valid_i),
    .req_type_i    (req_type_i),
    .char_code_i   (char_code_i),
    .read_col_i    (read_col_i),
    .read_row_i    (read_row_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_kind_o  (event_kind_o),
    .byte_value_o  (byte_value_o),
    .cell_col_o    (cell_col_o),
    .cell_row_o    (cell_row_o),
    .last_of_run_o (last_of_run_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

endmodule

/* bench/tb_text_console_cursor_engine_top.sv */
// Self-checking bench for text_console_cursor_engine_top: random and directed console
// requests against a cycle-free model of the screen buffer, cursor and output mode.
// Depends on tcce_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_text_console_cursor_engine_top;

  localparam int ROWS          = tcce_pkg::DefTextRows;
  localparam int COLS          = tcce_pkg::DefTextCols;
  localparam int SETTLE_CYCLES = ROWS * COLS + 2 * COLS + 32;
  localparam int STALL_LIMIT   = 20000;
  localparam int PHASE_WORDS   = 20;

  localparam logic [tcce_pkg::ReqW-1:0]   REQ_UNUSED = 2'd3;
  localparam logic [tcce_pkg::PaddrW-1:0] MODE_ADDR  = {tcce_pkg::REG_OUTPUT_MODE, 2'b00};

  typedef struct packed {
    logic [tcce_pkg::ReqW-1:0]  kind;
    logic [tcce_pkg::ByteW-1:0] ch;
    logic [tcce_pkg::ColW-1:0]  col;
    logic [tcce_pkg::RowW-1:0]  row;
  } console_req_t;

  typedef struct packed {
    logic [tcce_pkg::KindW-1:0] kind;
    logic [tcce_pkg::ByteW-1:0] value;
    logic [tcce_pkg::ColW-1:0]  col;
    logic [tcce_pkg::RowW-1:0]  row;
    logic                       last;
  } console_event_t;

  class console_mirror;
    logic [tcce_pkg::ByteW-1:0] screen [ROWS*COLS];
    int unsigned                cur_col;
    int unsigned                cur_row;
    logic [tcce_pkg::ModeW-1:0] mode;
    console_event_t             pending_events [$];
    int unsigned                fail_count;

    function new();
      foreach (screen[i]) screen[i] = '0;
      cur_col    = 0;
      cur_row    = 0;
      mode       = tcce_pkg::MODE_MIRROR;
      fail_count = 0;
    endfunction

    function void set_mode(logic [tcce_pkg::DataW-1:0] value);
      mode = (value > tcce_pkg::DataW'(tcce_pkg::MODE_MIRROR)) ? tcce_pkg::MODE_MIRROR
                                                                : value[tcce_pkg::ModeW-1:0];
    endfunction

    function void add_event(logic [tcce_pkg::KindW-1:0] kind,
                            logic [tcce_pkg::ByteW-1:0] value,
                            logic [tcce_pkg::ColW-1:0] col, logic [tcce_pkg::RowW-1:0] row);
      console_event_t ev;
      ev.kind  = kind;
      ev.value = value;
      ev.col   = col;
      ev.row   = row;
      ev.last  = 1'b0;
      pending_events.push_back(ev);
    endfunction

    function void next_line();
      cur_col = 0;
      cur_row++;
      if (cur_row >= ROWS) begin
        for (int i = 0; i < (ROWS - 1) * COLS; i++) screen[i] = screen[i+COLS];
        for (int i = (ROWS - 1) * COLS; i < ROWS * COLS; i++) screen[i] = tcce_pkg::CH_SPACE;
        cur_row = ROWS - 1;
        add_event(tcce_pkg::EVT_SCROLL, '0, '0, '0);
      end
    endfunction

    function void put_char(logic [tcce_pkg::ByteW-1:0] ch);
      int unsigned                pos;
      logic [tcce_pkg::ByteW-1:0] shown;
      if (mode != tcce_pkg::MODE_DISPLAY) add_event(tcce_pkg::EVT_SERIAL, ch, '0, '0);
      if (mode == tcce_pkg::MODE_SERIAL) return;
      if (ch == tcce_pkg::CH_CR) begin
        cur_col = 0;
        return;
      end
      if (ch == tcce_pkg::CH_LF) begin
        next_line();
        return;
      end
      pos = cur_row * COLS + cur_col;
      if (ch == tcce_pkg::CH_BS) begin
        if (cur_col > 0) begin
          cur_col--;
          pos--;
        end
        screen[pos] = tcce_pkg::CH_SPACE;
        add_event(tcce_pkg::EVT_DRAW, tcce_pkg::CH_SPACE, tcce_pkg::ColW'(cur_col),
                  tcce_pkg::RowW'(cur_row));
        return;
      end
      shown = (ch < tcce_pkg::CH_FIRST_PRNT || ch > tcce_pkg::CH_LAST_PRNT) ?
              tcce_pkg::CH_QMARK : ch;
      screen[pos] = shown;
      add_event(tcce_pkg::EVT_DRAW, shown, tcce_pkg::ColW'(cur_col), tcce_pkg::RowW'(cur_row));
      cur_col++;
      if (cur_col >= COLS) next_line();
    endfunction

    function void take_request(console_req_t r);
      int unsigned                was;
      logic [tcce_pkg::ByteW-1:0] cell_val;
      was = pending_events.size();
      case (r.kind)
        tcce_pkg::REQ_PUT: put_char(r.ch);
        tcce_pkg::REQ_CLEAR: begin
          foreach (screen[i]) screen[i] = tcce_pkg::CH_SPACE;
          cur_col = 0;
          cur_row = 0;
          if (mode != tcce_pkg::MODE_SERIAL) add_event(tcce_pkg::EVT_CLEAR, '0, '0, '0);
        end
        tcce_pkg::REQ_READ: begin
          cell_val = (r.col < COLS && r.row < ROWS) ? screen[r.row * COLS + r.col] : '0;
          add_event(tcce_pkg::EVT_READ, cell_val, r.col, r.row);
        end
        default: ;
      endcase
      if (pending_events.size() > was) pending_events[pending_events.size()-1].last = 1'b1;
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t mismatch %s: expected %0h, got %0h", $time, name, want, got);
        fail_count++;
      end
    endfunction

    function void match_event(logic [tcce_pkg::KindW-1:0] kind,
                              logic [tcce_pkg::ByteW-1:0] value,
                              logic [tcce_pkg::ColW-1:0] col, logic [tcce_pkg::RowW-1:0] row,
                              logic last);
      console_event_t want;
      if (pending_events.size() == 0) begin
        $display("%0t unexpected word: expected none, got kind %0h value %0h col %0h row %0h",
                 $time, kind, value, col, row);
        fail_count++;
        return;
      end
      want = pending_events.pop_front();
      check_field("event_kind", 8'(want.kind), 8'(kind));
      check_field("byte_value", want.value, value);
      check_field("cell_col", 8'(want.col), 8'(col));
      check_field("cell_row", 8'(want.row), 8'(row));
      check_field("last_of_run", 8'(want.last), 8'(last));
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [tcce_pkg::ReqW-1:0]     req_type_i;
  logic [tcce_pkg::ByteW-1:0]    char_code_i;
  logic [tcce_pkg::ColW-1:0]     read_col_i;
  logic [tcce_pkg::RowW-1:0]     read_row_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [tcce_pkg::KindW-1:0]    event_kind_o;
  logic [tcce_pkg::ByteW-1:0]    byte_value_o;
  logic [tcce_pkg::ColW-1:0]     cell_col_o;
  logic [tcce_pkg::RowW-1:0]     cell_row_o;
  logic                          last_of_run_o;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [tcce_pkg::PaddrW-1:0]   paddr;
  logic [tcce_pkg::DataW-1:0]    pwdata;
  logic [tcce_pkg::DataW-1:0]    prdata;
  logic                          pready;

  console_mirror mirror = new();
  int unsigned   burst_left = 0;
  int unsigned   words_sent = 0;
  int unsigned   quiet_cycles = 0;

  text_console_cursor_engine_top #(
    .TEXT_ROWS(ROWS),
    .TEXT_COLS(COLS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .char_code_i  (char_code_i),
    .read_col_i   (read_col_i),
    .read_row_i   (read_row_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_kind_o (event_kind_o),
    .byte_value_o (byte_value_o),
    .cell_col_o   (cell_col_o),
    .cell_row_o   (cell_row_o),
    .last_of_run_o(last_of_run_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic console_req_t make_req(logic [tcce_pkg::ReqW-1:0] kind,
                                            logic [tcce_pkg::ByteW-1:0] ch,
                                            logic [tcce_pkg::ColW-1:0] col,
                                            logic [tcce_pkg::RowW-1:0] row);
    console_req_t r;
    r.kind = kind;
    r.ch   = ch;
    r.col  = col;
    r.row  = row;
    return r;
  endfunction

  function automatic console_req_t rand_put(logic [tcce_pkg::ByteW-1:0] ch);
    return make_req(tcce_pkg::REQ_PUT, ch, tcce_pkg::ColW'($urandom_range(0, 63)),
                    tcce_pkg::RowW'($urandom_range(0, 31)));
  endfunction

  task automatic issue(console_req_t r);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i  = 1'b1;
    req_type_i  = r.kind;
    char_code_i = r.ch;
    read_col_i  = r.col;
    read_row_i  = r.row;
    do @(posedge clk_i); while (!in_ready_o);
    mirror.take_request(r);
    words_sent++;
  endtask

  // drain: everything delivered, then allow for a clear with no result
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (mirror.pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write_mode(logic [tcce_pkg::DataW-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = MODE_ADDR;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    mirror.set_mode(value);
    @(negedge clk_i);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if (prdata !== tcce_pkg::DataW'(mirror.mode)) begin
      $display("%0t mismatch output_mode readback: expected %0h, got %0h",
               $time, mirror.mode, prdata);
      mirror.fail_count++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic random_phase(int unsigned budget);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    start = words_sent;
    while (words_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(38, 45) : $urandom_range(0, 12);
        repeat (len) issue(rand_put(tcce_pkg::ByteW'($urandom_range(32, 126))));
        if ($urandom_range(0, 1) == 0) issue(rand_put(tcce_pkg::CH_CR));
        issue(rand_put(tcce_pkg::CH_LF));
      end else if (pick < 63) begin
        repeat ($urandom_range(1, 10)) issue(rand_put(tcce_pkg::CH_LF));
      end else if (pick < 78) begin
        issue(make_req(tcce_pkg::REQ_READ, tcce_pkg::ByteW'($urandom_range(0, 255)),
                       tcce_pkg::ColW'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                    : $urandom_range(0, COLS - 1)),
                       tcce_pkg::RowW'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                    : $urandom_range(0, ROWS - 1))));
      end else if (pick < 85) begin
        issue(rand_put(tcce_pkg::CH_BS));
      end else if (pick < 92) begin
        issue(rand_put(tcce_pkg::ByteW'($urandom_range(0, 255))));
      end else if (pick < 95) begin
        issue(rand_put(tcce_pkg::CH_CR));
      end else if (pick < 98) begin
        issue(make_req(REQ_UNUSED, tcce_pkg::ByteW'($urandom_range(0, 255)),
                       tcce_pkg::ColW'($urandom_range(0, 63)),
                       tcce_pkg::RowW'($urandom_range(0, 31))));
      end else begin
        issue(make_req(tcce_pkg::REQ_CLEAR, tcce_pkg::ByteW'($urandom_range(0, 255)),
                       tcce_pkg::ColW'($urandom_range(0, 63)),
                       tcce_pkg::RowW'($urandom_range(0, 31))));
      end
    end
  endtask

  initial begin : ready_pattern
    int unsigned style;
    int unsigned span;
    out_ready_i = 1'b1;
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(16, 200);
      repeat (span) begin
        @(negedge clk_i);
        case (style)
          0:       out_ready_i = 1'b1;
          1:       out_ready_i = ($urandom_range(0, 3) != 0);
          2:       out_ready_i = ($urandom_range(0, 1) == 0);
          default: out_ready_i = ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      mirror.match_event(event_kind_o, byte_value_o, cell_col_o, cell_row_o, last_of_run_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t timeout: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("text_console_cursor_engine_top test failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [tcce_pkg::DataW-1:0] mode_plan [6];
    mode_plan   = '{tcce_pkg::DataW'(tcce_pkg::MODE_DISPLAY),
                    tcce_pkg::DataW'(tcce_pkg::MODE_SERIAL), 32'd3,
                    tcce_pkg::DataW'(tcce_pkg::MODE_MIRROR),
                    tcce_pkg::DataW'(tcce_pkg::MODE_SERIAL), '1};
    in_valid_i  = 1'b0;
    req_type_i  = tcce_pkg::REQ_PUT;
    char_code_i = '0;
    read_col_i  = '0;
    read_row_i  = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    rst_ni      = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset contents, corners and out-of-range reads
    issue(make_req(tcce_pkg::REQ_READ, 8'h00, 6'd0, 5'd0));
    issue(make_req(tcce_pkg::REQ_READ, 8'hFF, 6'd63, 5'd31));
    issue(make_req(tcce_pkg::REQ_READ, 8'h00, tcce_pkg::ColW'(COLS - 1),
                   tcce_pkg::RowW'(ROWS - 1)));
    issue(make_req(tcce_pkg::REQ_READ, 8'h00, tcce_pkg::ColW'(COLS), 5'd0));
    issue(make_req(tcce_pkg::REQ_READ, 8'h00, 6'd0, tcce_pkg::RowW'(ROWS)));
    // printable edges and substituted bytes
    issue(make_req(tcce_pkg::REQ_PUT, 8'h41, 6'd63, 5'd31));
    issue(make_req(tcce_pkg::REQ_PUT, 8'h00, 6'd0, 5'd0));
    issue(make_req(tcce_pkg::REQ_PUT, 8'hFF, 6'd0, 5'd0));
    issue(make_req(tcce_pkg::REQ_PUT, 8'd31, 6'd0, 5'd0));
    issue(make_req(tcce_pkg::REQ_PUT, 8'd127, 6'd0, 5'd0));
    issue(make_req(tcce_pkg::REQ_PUT, tcce_pkg::CH_FIRST_PRNT, 6'd0, 5'd0));
    issue(make_req(tcce_pkg::REQ_PUT, tcce_pkg::CH_LAST_PRNT, 6'd0, 5'd0));
    issue(make_req(tcce_pkg::REQ_READ, 8'h00, 6'd0, 5'd0));
    // cursor moves: backspace mid-line, return, backspace at column 0, line feed
    issue(make_req(tcce_pkg::REQ_PUT, tcce_pkg::CH_BS, 6'd0, 5'd0));
    issue(make_req(tcce_pkg::REQ_PUT, tcce_pkg::CH_CR, 6'd0, 5'd0));
    issue(make_req(tcce_pkg::REQ_PUT, tcce_pkg::CH_BS, 6'd0, 5'd0));
    issue(make_req(tcce_pkg::REQ_PUT, tcce_pkg::CH_LF, 6'd0, 5'd0));
    issue(make_req(REQ_UNUSED, 8'hFF, 6'd63, 5'd31));
    issue(make_req(tcce_pkg::REQ_CLEAR, 8'h00, 6'd0, 5'd0));
    issue(make_req(tcce_pkg::REQ_READ, 8'h00, 6'd5, 5'd5));
    issue(make_req(tcce_pkg::REQ_PUT, 8'h7A, 6'd0, 5'd0));
    issue(make_req(tcce_pkg::REQ_PUT, tcce_pkg::CH_LF, 6'd0, 5'd0));

    foreach (mode_plan[i]) begin
      settle();
      apb_write_mode(mode_plan[i]);
      random_phase(PHASE_WORDS);
    end

    settle();
    if (mirror.fail_count == 0) begin
      $display("text_console_cursor_engine_top test passed");
    end else begin
      $display("text_console_cursor_engine_top test failed");
    end
    $finish;
  end

endmodule
